// File: rtl/core/char_lcd_nibble_write_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Character LCD nibble write sequencer - assertion macros
// Shared macros for concurrent checks on the sequencer ports.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH

// Check that is switched off while reset is high
`define LCD4_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also runs during reset
`define LCD4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/lcd4_pkg.sv
// ----------------------------------------------------------------------------
// lcd4_pkg
// Types and constants shared by the character LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lcd4_pkg;

   // Item kinds on the request channel
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_CMD   = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;
   localparam logic [1:0] KIND_INIT  = 2'd3;

   // Register indexes
   localparam int          CSR_ADDR_W        = 3;
   localparam logic [2:0]  CSR_EN_HIGH       = 3'd0;
   localparam logic [2:0]  CSR_EN_LOW        = 3'd1;
   localparam logic [2:0]  CSR_CLEAR_SETTLE  = 3'd2;
   localparam logic [2:0]  CSR_CMD_SETTLE    = 3'd3;
   localparam logic [2:0]  CSR_DATA_SETTLE   = 3'd4;
   localparam logic [2:0]  CSR_INIT_WAIT     = 3'd5;

   localparam logic [7:0]  CLEAR_CMD = 8'h01;
   localparam logic [2:0]  INIT_LEN  = 3'd6;

   // Timing registers
   typedef struct packed {
      logic [15:0] en_high;
      logic [15:0] en_low;
      logic [15:0] clear_settle;
      logic [15:0] cmd_settle;
      logic [15:0] data_settle;
      logic [15:0] init_wait;
   } cfg_type;

   // One result item, first field in the highest bit
   typedef struct packed {
      logic       rejected;
      logic       busy;
      logic [3:0] data_nibble;
      logic       enable_line;
      logic       register_select;
   } rsp_type;

   // Power-up command sequence
   function automatic logic [7:0] init_byte(input logic [2:0] step);
      logic [7:0] b;
      case (step)
         3'd0: b = 8'h33;
         3'd1: b = 8'h32;
         3'd2: b = 8'h28;
         3'd3: b = 8'h06;
         3'd4: b = 8'h0E;
         3'd5: b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// File: rtl/core/lcd4_cfg.sv
// ----------------------------------------------------------------------------
// lcd4_cfg
// Timing register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lcd4_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lcd4_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]                     csr_wdata,
   output lcd4_pkg::cfg_type               cfg
);

   lcd4_pkg::cfg_type cfg_ff, cfg_in;

   // Address decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            lcd4_pkg::CSR_EN_HIGH:      cfg_in.en_high      = csr_wdata;
            lcd4_pkg::CSR_EN_LOW:       cfg_in.en_low       = csr_wdata;
            lcd4_pkg::CSR_CLEAR_SETTLE: cfg_in.clear_settle = csr_wdata;
            lcd4_pkg::CSR_CMD_SETTLE:   cfg_in.cmd_settle   = csr_wdata;
            lcd4_pkg::CSR_DATA_SETTLE:  cfg_in.data_settle  = csr_wdata;
            lcd4_pkg::CSR_INIT_WAIT:    cfg_in.init_wait    = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.en_high      <= 16'd3;
         cfg_ff.en_low       <= 16'd3;
         cfg_ff.clear_settle <= 16'd4;
         cfg_ff.cmd_settle   <= 16'd1;
         cfg_ff.data_settle  <= 16'd1;
         cfg_ff.init_wait    <= 16'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/lcd4_core.sv
// ----------------------------------------------------------------------------
// lcd4_core
// Phase sequencer: one item per cycle updates the phase, tick count and pins.
// ----------------------------------------------------------------------------
module lcd4_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  logic [1:0]        kind,
   input  logic [7:0]        byte_value,
   input  lcd4_pkg::cfg_type cfg,
   output lcd4_pkg::rsp_type result
);

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_PRE_WAIT  = 3'd1,
      PH_HI_ON     = 3'd2,
      PH_HI_OFF    = 3'd3,
      PH_LO_ON     = 3'd4,
      PH_LO_OFF    = 3'd5,
      PH_SETTLE    = 3'd6,
      PH_POST_WAIT = 3'd7
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_data_ff, held_data_in;
   logic [2:0]  step_ff, step_in;
   logic        init_act_ff, init_act_in;
   logic [5:0]  pins_ff, pins_in;    // [5] RS, [4] E, [3:0] nibble

   logic [15:0] cnt_inc;
   logic [15:0] phase_len;
   logic [2:0]  step_nx;
   logic        start;
   logic [7:0]  start_byte;
   logic        start_data;
   logic        rej;

   // Length of the phase in progress
   always_comb begin
      case (phase_ff)
         PH_PRE_WAIT, PH_POST_WAIT: phase_len = cfg.init_wait;
         PH_HI_ON, PH_LO_ON:        phase_len = cfg.en_high;
         PH_HI_OFF, PH_LO_OFF:      phase_len = cfg.en_low;
         PH_SETTLE: begin
            if (held_data_ff)
               phase_len = cfg.data_settle;
            else if (held_byte_ff == lcd4_pkg::CLEAR_CMD)
               phase_len = cfg.clear_settle;
            else
               phase_len = cfg.cmd_settle;
         end
         default:                   phase_len = 16'd0;
      endcase
   end

   // Next-state logic
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      held_byte_in = held_byte_ff;
      held_data_in = held_data_ff;
      step_in      = step_ff;
      init_act_in  = init_act_ff;
      pins_in      = pins_ff;
      cnt_inc      = cnt_ff + 16'd1;
      step_nx      = step_ff + 3'd1;
      start        = 1'b0;
      start_byte   = byte_value;
      start_data   = 1'b0;
      rej          = 1'b0;

      if (item_valid) begin
         if (kind == lcd4_pkg::KIND_TICK) begin
            if (phase_ff != PH_IDLE) begin
               cnt_in = cnt_inc;
               if (cnt_inc >= phase_len) begin
                  cnt_in = 16'd0;
                  case (phase_ff)
                     PH_PRE_WAIT: begin
                        step_in    = 3'd0;
                        start      = 1'b1;
                        start_byte = lcd4_pkg::init_byte(3'd0);
                     end
                     PH_HI_ON: begin
                        pins_in[4] = 1'b0;
                        phase_in   = PH_HI_OFF;
                     end
                     PH_HI_OFF: begin
                        pins_in  = {pins_ff[5], 1'b1, held_byte_ff[3:0]};
                        phase_in = PH_LO_ON;
                     end
                     PH_LO_ON: begin
                        pins_in[4] = 1'b0;
                        phase_in   = PH_LO_OFF;
                     end
                     PH_LO_OFF: phase_in = PH_SETTLE;
                     PH_SETTLE: begin
                        if (init_act_ff) begin
                           step_in = step_nx;
                           if (step_nx < lcd4_pkg::INIT_LEN) begin
                              start      = 1'b1;
                              start_byte = lcd4_pkg::init_byte(step_nx);
                           end else begin
                              phase_in = PH_POST_WAIT;
                           end
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end
                     PH_POST_WAIT: begin
                        init_act_in = 1'b0;
                        phase_in    = PH_IDLE;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
         end else if (phase_ff != PH_IDLE) begin
            rej = 1'b1;
         end else if (kind == lcd4_pkg::KIND_INIT) begin
            init_act_in = 1'b1;
            step_in     = 3'd0;
            pins_in     = {pins_ff[5], 5'd0};
            phase_in    = PH_PRE_WAIT;
            cnt_in      = 16'd0;
         end else begin
            start      = 1'b1;
            start_data = (kind == lcd4_pkg::KIND_DATA);
         end
      end

      // Drive the high nibble with enable up
      if (start) begin
         held_byte_in = start_byte;
         held_data_in = start_data;
         pins_in      = {start_data, 1'b1, start_byte[7:4]};
         phase_in     = PH_HI_ON;
         cnt_in       = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= 16'd0;
         held_byte_ff <= 8'd0;
         held_data_ff <= 1'b0;
         step_ff      <= 3'd0;
         init_act_ff  <= 1'b0;
         pins_ff      <= 6'd0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         held_byte_ff <= held_byte_in;
         held_data_ff <= held_data_in;
         step_ff      <= step_in;
         init_act_ff  <= init_act_in;
         pins_ff      <= pins_in;
      end
   end

   // Result reflects the pins after this item
   assign result.register_select = pins_in[5];
   assign result.enable_line     = pins_in[4];
   assign result.data_nibble     = pins_in[3:0];
   assign result.busy            = (phase_in != PH_IDLE);
   assign result.rejected        = rej;

endmodule

// File: rtl/core/lcd4_obuf.sv
// ----------------------------------------------------------------------------
// lcd4_obuf
// Two-entry result buffer; keeps the request side open while a result waits.
// ----------------------------------------------------------------------------
module lcd4_obuf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcd4_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output lcd4_pkg::rsp_type out_data
);

   lcd4_pkg::rsp_type e0_ff, e0_in, e1_ff, e1_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              pop;

   assign pop = (cnt_ff != 2'd0) && out_ready;

   // Shift-down queue update
   always_comb begin
      e0_in  = e0_ff;
      e1_in  = e1_ff;
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) e0_in = push_data;
            else                e1_in = push_data;
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            e0_in  = e1_ff;
            cnt_in = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               e0_in = push_data;
            end else begin
               e0_in = e1_ff;
               e1_in = push_data;
            end
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      e0_ff <= e0_in;
      e1_ff <= e1_in;
   end

   assign space     = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = e0_ff;

endmodule

// File: rtl/core/char_lcd_nibble_write_sequencer.sv
// Results are registered in the result buffer and leave it in order.
// Throughput: one item per cycle while the buffer has room; single-pass update.
// A two-entry result buffer keeps req_tready high while one result waits.
// Reset: synchronous, active high; phase idle, pins low, timing registers
// back to their defaults, result buffer emptied.
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// 4-bit character LCD write sequencer driven by tick and request items.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] byte_value
   input  logic [1:0]                      req_tuser,  // [1:0] kind
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] register_select, [1] enable_line, [5:2] data_nibble, [6] busy,
   // [7] rejected
   output logic [7:0]                      rsp_tdata,
   // configuration
   input  logic                            csr_wr_en,
   input  logic [lcd4_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [15:0]                     csr_wdata
);

   lcd4_pkg::cfg_type cfg;
   lcd4_pkg::rsp_type core_rsp;
   lcd4_pkg::rsp_type buf_rsp;
   logic              accept;

   assign accept = req_tvalid && req_tready;

   lcd4_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lcd4_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .kind       (req_tuser),
      .byte_value (req_tdata),
      .cfg        (cfg),
      .result     (core_rsp)
   );

   lcd4_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (core_rsp),
      .space     (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buf_rsp)
   );

   assign rsp_tdata = buf_rsp;

endmodule

// File: rtl/core/lcd4_checker.sv
// ----------------------------------------------------------------------------
// lcd4_checker
// Port-level checks for the character LCD nibble write sequencer.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_write_sequencer_defines.svh"

module lcd4_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // A stalled result stays put
   `LCD4_ASSERT(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
      "result changed while stalled")

   // Buffer comes out of reset empty and open
   `LCD4_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> req_tready && !rsp_tvalid,
      "buffer not empty after reset")

   // An item into an empty buffer shows up next cycle
   `LCD4_ASSERT(a_rsp_latency, clock, reset,
      req_tvalid && req_tready && !rsp_tvalid |=> rsp_tvalid,
      "result missing after accept")

   // A rejected request always reports busy
   `LCD4_ASSERT(a_rej_busy, clock, reset,
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[6],
      "rejected without busy")

   // Enable strobe only while a transfer runs
   `LCD4_ASSERT(a_en_busy, clock, reset,
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[6],
      "enable high while idle")

endmodule

bind char_lcd_nibble_write_sequencer lcd4_checker u_lcd4_checker (.*);

// File: verif/tb_char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_write_sequencer
// Self-checking bench for the 4-bit character LCD write sequencer. A directed
// table covers idle ticks, command/data/init requests, requests refused while
// busy, the clear settle, zero and full-scale timing registers, and a register
// shrunk below a running count. Random traffic follows under several timing
// settings. Results are checked by typed-in rows or a pin/phase predictor.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_write_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT       = 600000;
   localparam int          ITEMS_PER_SETTING = 205;
   localparam int          SETTINGS_COUNT    = 6;
   localparam int          DRAIN_CYCLES      = 3;
   localparam int          REPORT_LIMIT      = 10;
   localparam logic [2:0]  CSR_SPARE_LO      = 3'd6;
   localparam logic [2:0]  CSR_SPARE_HI      = 3'd7;
   // power-up command bytes, first byte in the lowest bits
   localparam logic [47:0] POWER_UP_BYTES    = {8'h01, 8'h0E, 8'h06, 8'h28, 8'h32, 8'h33};

   typedef enum logic [2:0] {
      ST_IDLE, ST_PRE_WAIT, ST_HI_ON, ST_HI_OFF, ST_LO_ON, ST_LO_OFF, ST_SETTLE, ST_POST_WAIT
   } lcd_phase_type;

   // one row of the directed table: an item (repeated) or a register write
   typedef struct {
      logic              is_csr;
      logic [2:0]        addr;
      logic [15:0]       wdata;
      logic [1:0]        kind;
      logic [7:0]        value;
      int                reps;
      logic              fixed;
      lcd4_pkg::rsp_type want;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [1:0]  req_tuser  = lcd4_pkg::KIND_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_wr_en  = 1'b0;
   logic [lcd4_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [15:0] csr_wdata  = '0;

   // typed-in expectation travels with the item it belongs to
   logic              row_fixed     = 1'b0;
   lcd4_pkg::rsp_type row_fixed_rsp = '0;

   // predictor state
   lcd4_pkg::cfg_type lcd_cfg;
   lcd_phase_type     lcd_ph;
   logic [15:0]       lcd_cnt;
   logic [7:0]        lcd_byte;
   logic              lcd_is_data;
   logic [2:0]        lcd_step;
   logic              lcd_init_on;
   logic              lcd_rs;
   logic              lcd_en;
   logic [3:0]        lcd_nib;
   logic              lcd_moved;

   lcd4_pkg::rsp_type expected_pins [$];
   dir_row_type       directed_rows [$];
   int                effective_items = 0;
   int                results_seen    = 0;
   int                failures        = 0;
   int                cycles          = 0;
   int                stall_left      = 0;
   logic              quiet           = 1'b0;

   char_lcd_nibble_write_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   function automatic lcd4_pkg::rsp_type lcd_pins(input logic rs, input logic en,
                                                  input logic [3:0] nib,
                                                  input logic busy, input logic rej);
      lcd4_pkg::rsp_type r;
      r.register_select = rs;
      r.enable_line     = en;
      r.data_nibble     = nib;
      r.busy            = busy;
      r.rejected        = rej;
      return r;
   endfunction

   function automatic void lcd_reset();
      lcd_cfg.en_high      = 16'd3;
      lcd_cfg.en_low       = 16'd3;
      lcd_cfg.clear_settle = 16'd4;
      lcd_cfg.cmd_settle   = 16'd1;
      lcd_cfg.data_settle  = 16'd1;
      lcd_cfg.init_wait    = 16'd5;
      lcd_ph      = ST_IDLE;
      lcd_cnt     = '0;
      lcd_byte    = '0;
      lcd_is_data = 1'b0;
      lcd_step    = '0;
      lcd_init_on = 1'b0;
      lcd_rs      = 1'b0;
      lcd_en      = 1'b0;
      lcd_nib     = '0;
   endfunction

   function automatic void lcd_write_reg(input logic [2:0] addr, input logic [15:0] data);
      case (addr)
         lcd4_pkg::CSR_EN_HIGH:      lcd_cfg.en_high      = data;
         lcd4_pkg::CSR_EN_LOW:       lcd_cfg.en_low       = data;
         lcd4_pkg::CSR_CLEAR_SETTLE: lcd_cfg.clear_settle = data;
         lcd4_pkg::CSR_CMD_SETTLE:   lcd_cfg.cmd_settle   = data;
         lcd4_pkg::CSR_DATA_SETTLE:  lcd_cfg.data_settle  = data;
         lcd4_pkg::CSR_INIT_WAIT:    lcd_cfg.init_wait    = data;
         default: ;
      endcase
   endfunction

   // high nibble goes out first with enable raised
   function automatic void lcd_load_byte(input logic [7:0] b, input logic is_data);
      lcd_byte    = b;
      lcd_is_data = is_data;
      lcd_nib     = b[7:4];
      lcd_en      = 1'b1;
      lcd_rs      = is_data;
      lcd_ph      = ST_HI_ON;
      lcd_cnt     = '0;
   endfunction

   function automatic logic [15:0] lcd_phase_length();
      case (lcd_ph)
         ST_PRE_WAIT, ST_POST_WAIT: return lcd_cfg.init_wait;
         ST_HI_ON, ST_LO_ON:        return lcd_cfg.en_high;
         ST_HI_OFF, ST_LO_OFF:      return lcd_cfg.en_low;
         ST_SETTLE: begin
            if (lcd_is_data)
               return lcd_cfg.data_settle;
            return (lcd_byte == lcd4_pkg::CLEAR_CMD) ? lcd_cfg.clear_settle
                                                     : lcd_cfg.cmd_settle;
         end
         default: return 16'd0;
      endcase
   endfunction

   function automatic void lcd_next_phase();
      lcd_cnt = '0;
      case (lcd_ph)
         ST_PRE_WAIT: begin
            lcd_step = '0;
            lcd_load_byte(POWER_UP_BYTES[7:0], 1'b0);
         end
         ST_HI_ON: begin
            lcd_en = 1'b0;
            lcd_ph = ST_HI_OFF;
         end
         ST_HI_OFF: begin
            lcd_nib = lcd_byte[3:0];
            lcd_en  = 1'b1;
            lcd_ph  = ST_LO_ON;
         end
         ST_LO_ON: begin
            lcd_en = 1'b0;
            lcd_ph = ST_LO_OFF;
         end
         ST_LO_OFF: lcd_ph = ST_SETTLE;
         ST_SETTLE: begin
            if (lcd_init_on) begin
               lcd_step = lcd_step + 3'd1;
               if (lcd_step < lcd4_pkg::INIT_LEN)
                  lcd_load_byte(POWER_UP_BYTES[lcd_step*8 +: 8], 1'b0);
               else
                  lcd_ph = ST_POST_WAIT;
            end else begin
               lcd_ph = ST_IDLE;
            end
         end
         ST_POST_WAIT: begin
            lcd_init_on = 1'b0;
            lcd_ph      = ST_IDLE;
         end
         default: lcd_ph = ST_IDLE;
      endcase
   endfunction

   // pins and status after one item; lcd_moved tells whether it did anything
   function automatic lcd4_pkg::rsp_type lcd_pins_after(input logic [1:0] kind,
                                                        input logic [7:0] value);
      logic refused;
      refused   = 1'b0;
      lcd_moved = 1'b1;
      if (kind == lcd4_pkg::KIND_TICK) begin
         if (lcd_ph != ST_IDLE) begin
            lcd_cnt = lcd_cnt + 16'd1;
            if (lcd_cnt >= lcd_phase_length())
               lcd_next_phase();
         end else begin
            lcd_moved = 1'b0;
         end
      end else if (lcd_ph != ST_IDLE) begin
         refused   = 1'b1;
         lcd_moved = 1'b0;
      end else if (kind == lcd4_pkg::KIND_INIT) begin
         // init wait: enable and data low, register select untouched
         lcd_init_on = 1'b1;
         lcd_step    = '0;
         lcd_en      = 1'b0;
         lcd_nib     = '0;
         lcd_ph      = ST_PRE_WAIT;
         lcd_cnt     = '0;
      end else begin
         lcd_load_byte(value, kind == lcd4_pkg::KIND_DATA);
      end
      return lcd_pins(lcd_rs, lcd_en, lcd_nib, lcd_ph != ST_IDLE, refused);
   endfunction

   // ------------------------------------------------------- monitor and check
   always @(posedge clock) begin
      lcd4_pkg::rsp_type got;
      lcd4_pkg::rsp_type want;
      if (reset) begin
         lcd_reset();
         expected_pins.delete();
      end else begin
         if (csr_wr_en)
            lcd_write_reg(csr_addr, csr_wdata);
         if (req_tvalid && req_tready) begin
            want = lcd_pins_after(req_tuser, req_tdata);
            if (lcd_moved)
               effective_items++;
            expected_pins.push_back(row_fixed ? row_fixed_rsp : want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = lcd4_pkg::rsp_type'(rsp_tdata);
            results_seen++;
            if (expected_pins.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("result %0d: %h arrived with nothing expected", results_seen,
                           rsp_tdata);
            end else begin
               want = expected_pins.pop_front();
               if (got.register_select !== want.register_select ||
                   got.enable_line !== want.enable_line ||
                   got.data_nibble !== want.data_nibble ||
                   got.busy !== want.busy ||
                   got.rejected !== want.rejected) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display({"result %0d (exp/got): rs %b/%b en %b/%b nibble %h/%h ",
                               "busy %b/%b rejected %b/%b"}, results_seen,
                              want.register_select, got.register_select,
                              want.enable_line, got.enable_line,
                              want.data_nibble, got.data_nibble,
                              want.busy, got.busy, want.rejected, got.rejected);
               end
            end
         end
      end
   end

   // result side back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 19) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // --------------------------------------------------------------- stimulus
   task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
                            input logic fixed, input lcd4_pkg::rsp_type want);
      req_tvalid    <= 1'b1;
      req_tuser     <= kind;
      req_tdata     <= value;
      row_fixed     <= fixed;
      row_fixed_rsp <= want;
      do @(posedge clock); while (!req_tready);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // wait until every expected item has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [15:0] data);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void add_item(input logic [1:0] kind, input logic [7:0] value,
                                    input int reps, input logic fixed,
                                    input lcd4_pkg::rsp_type want);
      dir_row_type r;
      r        = '{default: '0};
      r.kind   = kind;
      r.value  = value;
      r.reps   = reps;
      r.fixed  = fixed;
      r.want   = want;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_csr(input logic [2:0] addr, input logic [15:0] data);
      dir_row_type r;
      r        = '{default: '0};
      r.is_csr = 1'b1;
      r.addr   = addr;
      r.wdata  = data;
      directed_rows.push_back(r);
   endfunction

   initial begin
      dir_row_type row;
      logic [1:0]  kind;
      logic [7:0]  value;
      logic [15:0] wval;
      int          pick;
      int          target;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      // tick while idle: nothing moves, byte ignored
      add_item(lcd4_pkg::KIND_TICK, 8'hFF, 1, 1'b1,
               lcd_pins(1'b0, 1'b0, 4'h0, 1'b0, 1'b0));
      // zero timing acts like one tick per phase
      for (logic [2:0] r = lcd4_pkg::CSR_EN_HIGH; r <= lcd4_pkg::CSR_INIT_WAIT; r++)
         add_csr(r, 16'h0000);
      add_item(lcd4_pkg::KIND_DATA, 8'h00, 1, 1'b1,
               lcd_pins(1'b1, 1'b1, 4'h0, 1'b1, 1'b0));
      // requests while busy are refused
      add_item(lcd4_pkg::KIND_CMD,  8'hA5, 1, 1'b1,
               lcd_pins(1'b1, 1'b1, 4'h0, 1'b1, 1'b1));
      add_item(lcd4_pkg::KIND_INIT, 8'h00, 1, 1'b1,
               lcd_pins(1'b1, 1'b1, 4'h0, 1'b1, 1'b1));
      add_item(lcd4_pkg::KIND_TICK, 8'h00, 5, 1'b0, '0);
      // clear command uses its own settle
      add_item(lcd4_pkg::KIND_CMD,  lcd4_pkg::CLEAR_CMD, 1, 1'b1,
               lcd_pins(1'b0, 1'b1, 4'h0, 1'b1, 1'b0));
      add_item(lcd4_pkg::KIND_TICK, 8'h00, 5, 1'b0, '0);
      add_item(lcd4_pkg::KIND_DATA, 8'hFF, 1, 1'b1,
               lcd_pins(1'b1, 1'b1, 4'hF, 1'b1, 1'b0));
      add_item(lcd4_pkg::KIND_TICK, 8'h55, 5, 1'b0, '0);
      // init keeps register select from the last data byte
      add_item(lcd4_pkg::KIND_INIT, 8'h00, 1, 1'b1,
               lcd_pins(1'b1, 1'b0, 4'h0, 1'b1, 1'b0));
      add_item(lcd4_pkg::KIND_DATA, 8'h3C, 1, 1'b1,
               lcd_pins(1'b1, 1'b0, 4'h0, 1'b1, 1'b1));
      add_item(lcd4_pkg::KIND_TICK, 8'hAA, 33, 1'b0, '0);
      // full-scale timing, spare indexes ignored
      for (logic [2:0] r = lcd4_pkg::CSR_EN_HIGH; r <= lcd4_pkg::CSR_INIT_WAIT; r++)
         add_csr(r, 16'hFFFF);
      add_csr(CSR_SPARE_LO, 16'h0000);
      add_csr(CSR_SPARE_HI, 16'hFFFF);
      add_item(lcd4_pkg::KIND_CMD,  8'h5A, 1, 1'b1,
               lcd_pins(1'b0, 1'b1, 4'h5, 1'b1, 1'b0));
      add_item(lcd4_pkg::KIND_TICK, 8'h00, 4, 1'b0, '0);
      // shrink the running phase below its count: it ends on the next tick
      add_csr(lcd4_pkg::CSR_EN_HIGH, 16'h0001);
      add_item(lcd4_pkg::KIND_TICK, 8'h00, 3, 1'b0, '0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.is_csr) begin
            drain();
            csr_write(row.addr, row.wdata);
         end else begin
            repeat (row.reps) send_item(row.kind, row.value, row.fixed, row.want);
         end
      end

      // random traffic under several timing settings; last one runs without gaps
      for (int s = 0; s < SETTINGS_COUNT; s++) begin
         drain();
         quiet = (s == SETTINGS_COUNT - 1);
         for (logic [2:0] r = lcd4_pkg::CSR_EN_HIGH; r <= lcd4_pkg::CSR_INIT_WAIT; r++) begin
            if (s == 0)
               wval = 16'($urandom_range(0, 1));
            else if (s == 2)
               wval = 16'($urandom_range(8, 30));
            else
               wval = 16'($urandom_range(0, 5));
            csr_write(r, wval);
         end
         wval = 16'($urandom);
         csr_write(s[0] ? CSR_SPARE_HI : CSR_SPARE_LO, wval);

         target = effective_items + ITEMS_PER_SETTING;
         while (effective_items < target) begin
            // mostly well-formed: request when idle, ticks while busy
            if (lcd_ph == ST_IDLE) begin
               pick = $urandom_range(0, 99);
               if (pick < 12)
                  kind = lcd4_pkg::KIND_TICK;
               else if (pick < 50)
                  kind = lcd4_pkg::KIND_CMD;
               else if (pick < 88)
                  kind = lcd4_pkg::KIND_DATA;
               else
                  kind = lcd4_pkg::KIND_INIT;
            end else if ($urandom_range(0, 19) == 0) begin
               kind = 2'($urandom_range(lcd4_pkg::KIND_CMD, lcd4_pkg::KIND_INIT));
            end else begin
               kind = lcd4_pkg::KIND_TICK;
            end
            value = ($urandom_range(0, 4) == 0) ? lcd4_pkg::CLEAR_CMD : 8'($urandom);
            send_item(kind, value, 1'b0, '0);
         end
      end

      drain();
      failures += expected_pins.size();
      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
